/* src/tcr_pkg.sv */
// Package for the token class recognizer: state codes, class codes and
// the character-class transition and keyword tables. No dependencies.
package tcr_pkg;

  typedef logic [3:0] dfa_state_t;
  typedef logic [2:0] tok_class_t;
  typedef logic [7:0] char_t;
  typedef logic [2:0] char_pos_t;
  typedef logic [3:0] kw_mask_t;

  localparam int unsigned NUM_KW = 4;

  // Recognizer states
  localparam dfa_state_t ST_START     = 4'd0;
  localparam dfa_state_t ST_BIN_DIG   = 4'd1;
  localparam dfa_state_t ST_DEC_DIG   = 4'd2;
  localparam dfa_state_t ST_SIGN      = 4'd3;
  localparam dfa_state_t ST_IDENT     = 4'd4;
  localparam dfa_state_t ST_BIN_B     = 4'd5;
  localparam dfa_state_t ST_HEX_BODY  = 4'd6;
  localparam dfa_state_t ST_POINT     = 4'd7;
  localparam dfa_state_t ST_HEX_H     = 4'd8;
  localparam dfa_state_t ST_SGN_INT   = 4'd9;
  localparam dfa_state_t ST_FRAC      = 4'd10;
  localparam dfa_state_t ST_EXP_E     = 4'd11;
  localparam dfa_state_t ST_EXP_SIGN  = 4'd12;
  localparam dfa_state_t ST_EXP_DIG   = 4'd13;
  localparam dfa_state_t ST_HEX_ALPHA = 4'd14;
  localparam dfa_state_t ST_DEAD      = 4'd15;

  // Class codes
  localparam tok_class_t CLS_INTEGER    = 3'd0;
  localparam tok_class_t CLS_DECIMAL    = 3'd1;
  localparam tok_class_t CLS_SCIENTIFIC = 3'd2;
  localparam tok_class_t CLS_HEX        = 3'd3;
  localparam tok_class_t CLS_BINARY     = 3'd4;
  localparam tok_class_t CLS_KEYWORD    = 3'd5;
  localparam tok_class_t CLS_IDENT      = 3'd6;
  localparam tok_class_t CLS_INVALID    = 3'd7;

  localparam char_pos_t POS_MAX = 3'd6;

  function automatic logic is_dig(input char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input char_t c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_hexl(input char_t c);
    return (c >= 8'h41) && (c <= 8'h46);
  endfunction

  function automatic logic is_hex(input char_t c);
    return is_dig(c) || is_hexl(c);
  endfunction

  function automatic logic is_sign(input char_t c);
    return (c == 8'h2B) || (c == 8'h2D);
  endfunction

  // One table step; ST_DEAD means no transition
  function automatic dfa_state_t next_state(input dfa_state_t s, input char_t c);
    logic bin, pt, hh, und, nz;
    bin = (c == 8'h30) || (c == 8'h31);
    pt  = (c == 8'h2E);
    hh  = (c == 8'h48);
    und = (c == 8'h5F);
    nz  = is_dig(c) && (c != 8'h30);
    unique case (s)
      ST_START: begin
        if (is_dig(c))        return bin ? ST_BIN_DIG : ST_DEC_DIG;
        else if (is_alpha(c)) return is_hexl(c) ? ST_HEX_ALPHA : ST_IDENT;
        else if (is_sign(c))  return ST_SIGN;
        else                  return ST_DEAD;
      end
      ST_BIN_DIG: begin
        if (is_dig(c))       return bin ? ST_BIN_DIG : ST_DEC_DIG;
        else if (is_hexl(c)) return (c == 8'h42) ? ST_BIN_B : ST_HEX_BODY;
        else if (pt)         return ST_POINT;
        else if (hh)         return ST_HEX_H;
        else                 return ST_DEAD;
      end
      ST_DEC_DIG: begin
        if (is_hex(c)) return is_dig(c) ? ST_DEC_DIG : ST_HEX_BODY;
        else if (pt)   return ST_POINT;
        else if (hh)   return ST_HEX_H;
        else           return ST_DEAD;
      end
      ST_SIGN:  return is_dig(c) ? ST_SGN_INT : ST_DEAD;
      ST_IDENT: return (is_alpha(c) || is_dig(c) || und) ? ST_IDENT : ST_DEAD;
      ST_BIN_B, ST_HEX_BODY: begin
        if (is_hex(c)) return ST_HEX_BODY;
        else if (hh)   return ST_HEX_H;
        else           return ST_DEAD;
      end
      ST_POINT: return is_dig(c) ? ST_FRAC : ST_DEAD;
      ST_SGN_INT: begin
        if (is_dig(c)) return ST_SGN_INT;
        else if (pt)   return ST_POINT;
        else           return ST_DEAD;
      end
      ST_FRAC: begin
        if (is_dig(c))        return ST_FRAC;
        else if (c == 8'h45)  return ST_EXP_E;
        else                  return ST_DEAD;
      end
      ST_EXP_E: begin
        if (is_sign(c)) return ST_EXP_SIGN;
        else            return nz ? ST_EXP_DIG : ST_DEAD;
      end
      ST_EXP_SIGN: return nz ? ST_EXP_DIG : ST_DEAD;
      ST_EXP_DIG:  return is_dig(c) ? ST_EXP_DIG : ST_DEAD;
      ST_HEX_ALPHA: begin
        if (is_hex(c))        return ST_HEX_ALPHA;
        else if (hh)          return ST_HEX_H;
        else if (is_alpha(c)) return ST_IDENT;
        else                  return ST_DEAD;
      end
      default: return ST_DEAD;
    endcase
  endfunction

  function automatic tok_class_t class_of(input dfa_state_t s);
    unique case (s)
      ST_BIN_DIG, ST_DEC_DIG, ST_SGN_INT: return CLS_INTEGER;
      ST_FRAC:                            return CLS_DECIMAL;
      ST_EXP_DIG:                         return CLS_SCIENTIFIC;
      ST_HEX_H:                           return CLS_HEX;
      ST_BIN_B:                           return CLS_BINARY;
      ST_IDENT, ST_HEX_ALPHA:             return CLS_IDENT;
      default:                            return CLS_INVALID;
    endcase
  endfunction

  // Keywords: 0 while, 1 else, 2 end, 3 print
  function automatic char_pos_t kw_len(input logic [1:0] k);
    unique case (k)
      2'd0:    return 3'd5;
      2'd1:    return 3'd4;
      2'd2:    return 3'd3;
      default: return 3'd5;
    endcase
  endfunction

  function automatic char_t kw_char(input logic [1:0] k, input char_pos_t p);
    char_t w [5];
    w = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    unique case (k)
      2'd0:    w = '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65};
      2'd1:    w = '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00};
      2'd2:    w = '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00};
      default: w = '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74};
    endcase
    if (p < 3'd5) return w[p];
    else          return 8'h00;
  endfunction

endpackage

/* src/token_class_recognizer.sv */
// Token class recognizer: per-character state machine with keyword
// tracking and a registered class output. Depends on tcr_pkg.
// A token's class word is registered and appears in the cycle after its last character is accepted.
// Throughput: one character per cycle; the single-step table update and the
// one-deep output register set this, stalling only while a class word waits.
// Reset (synchronous, rst_n low): start state, keyword set full, position 0,
// output empty.
module token_class_recognizer
  import tcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_class
);

  // Token state, advanced on each accepted character and restarted after a token's last
  dfa_state_t dfa_state_r, dfa_state_nxt;
  logic       dead_r, dead_nxt;
  kw_mask_t   kw_cand_r, kw_cand_nxt;
  char_pos_t  char_pos_r, char_pos_nxt;

  // Output register
  logic       out_valid_r;
  tok_class_t out_class_r;
  tok_class_t class_nxt;

  dfa_state_t step_state;
  logic       in_acc;

  // Take a new character whenever the output slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    step_state   = next_state(dfa_state_r, in_char_code);
    dfa_state_nxt = dfa_state_r;
    dead_nxt      = dead_r;
    // Drop into the dead flag when the table has no transition
    if (!dead_r) begin
      if (step_state == ST_DEAD) begin
        dead_nxt      = 1'b1;
        dfa_state_nxt = ST_START;
      end else begin
        dfa_state_nxt = step_state;
      end
    end

    // Knock out keywords that no longer match at this position
    kw_cand_nxt = kw_cand_r;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((char_pos_r >= kw_len(2'(k))) ||
          (kw_char(2'(k), char_pos_r) != in_char_code)) begin
        kw_cand_nxt[k] = 1'b0;
      end
    end

    // Class of the token if this is its last character; keyword wins
    class_nxt = dead_nxt ? CLS_INVALID : class_of(dfa_state_nxt);
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_cand_nxt[k] && ((char_pos_r + 3'd1) == kw_len(2'(k)))) begin
        class_nxt = CLS_KEYWORD;
      end
    end

    // Saturate the position past the longest keyword
    char_pos_nxt = (char_pos_r < POS_MAX) ? (char_pos_r + 3'd1) : POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_state_r <= ST_START;
      dead_r      <= 1'b0;
      kw_cand_r   <= '1;
      char_pos_r  <= '0;
    end else if (in_acc) begin
      if (in_last_char) begin
        // End of token: return to the start of the next one
        dfa_state_r <= ST_START;
        dead_r      <= 1'b0;
        kw_cand_r   <= '1;
        char_pos_r  <= '0;
      end else begin
        dfa_state_r <= dfa_state_nxt;
        dead_r      <= dead_nxt;
        kw_cand_r   <= kw_cand_nxt;
        char_pos_r  <= char_pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: hold until drained, load on a token's final character
  always_ff @(posedge clk) begin
    if (in_acc && in_last_char) begin
      out_class_r <= class_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_class = out_class_r;

`ifndef SYNTHESIS
  a_dead_parks_start: assert property (@(posedge clk) disable iff (!rst_n)
    dead_r |-> (dfa_state_r == ST_START))
    else $error("dead token left recognizer away from start");

  a_never_dead_code: assert property (@(posedge clk) disable iff (!rst_n)
    dfa_state_r != ST_DEAD)
    else $error("dead code stored as recognizer state");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    char_pos_r <= POS_MAX)
    else $error("character position beyond saturation");

  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_char) |=> out_valid_r)
    else $error("final character produced no class word");

  a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_char) |=>
      (char_pos_r == 3'd0) && (kw_cand_r == 4'hF) && !dead_r)
    else $error("token state not restarted after final character");
`endif

endmodule
